### src/lte_pkg.sv
// Shared types and constants for the LRU table with age and size eviction.
package lte_pkg;

    localparam int KEY_W     = 64;
    localparam int TIME_W    = 32;
    localparam int CNT32_W   = 32;
    localparam int THR_W     = 5;
    localparam int OCC_W     = 5;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_TICK   = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        STS_ADDED     = 3'd0,
        STS_REFRESHED = 3'd1,
        STS_FULL      = 3'd2,
        STS_REMOVED   = 3'd3,
        STS_NOT_FOUND = 3'd4,
        STS_EVICTED   = 3'd5,
        STS_TICK_NONE = 3'd6,
        STS_CLEARED   = 3'd7
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIZE_THR  = 2'd0,
        CFG_AGE_THR   = 2'd1,
        CFG_CLEAN_INT = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ES_IDLE,
        ES_EXEC,
        ES_EVICT
    } eng_state_t;

    typedef struct packed {
        op_t              op;
        logic [KEY_W-1:0] key;
    } in_item_t;

    typedef struct packed {
        status_t          status;
        logic [KEY_W-1:0] evicted_key;
        logic [OCC_W-1:0] occupancy;
        logic             last;
    } out_item_t;

endpackage

### src/lte_front.sv
// Input front end: accepts items into a two-entry queue ahead of the engine.
module lte_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  lte_pkg::in_item_t s_data,
    input  logic              s_valid,
    output logic              s_ready,
    output lte_pkg::in_item_t q_item,
    output logic              q_valid,
    input  logic              q_ready
);
    import lte_pkg::*;

    in_item_t   mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= s_data;
        end
    end

endmodule

### src/lte_engine.sv
// Table engine: entry storage, recency ranks, timekeeping, eviction and result register.
module lte_engine #(
    parameter int DEPTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  lte_pkg::in_item_t                   job,
    input  logic                                job_valid,
    output logic                                job_ready,
    input  logic                                cfg_wen,
    input  logic [lte_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lte_pkg::CFG_W-1:0]           cfg_wdata,
    output lte_pkg::out_item_t                  m_data,
    output logic                                m_valid,
    input  logic                                m_ready
);
    import lte_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CW    = (CNT_W > THR_W) ? CNT_W : THR_W;

    logic [KEY_W-1:0]  key_reg   [DEPTH];
    logic [KEY_W-1:0]  key_next  [DEPTH];
    logic [TIME_W-1:0] stamp_reg [DEPTH];
    logic [TIME_W-1:0] stamp_next[DEPTH];
    logic [IDX_W-1:0]  rank_reg  [DEPTH];
    logic [IDX_W-1:0]  rank_next [DEPTH];
    logic [DEPTH-1:0]  valid_reg, valid_next;
    logic [CNT_W-1:0]  occ_reg, occ_next;
    logic [TIME_W-1:0] time_reg, time_next;
    logic [CNT32_W-1:0] icnt_reg, icnt_next;
    logic [THR_W-1:0]  thr_reg, thr_next;
    logic [CFG_W-1:0]  age_thr_reg, age_thr_next;
    logic [CFG_W-1:0]  clean_reg, clean_next;
    eng_state_t        state_reg, state_next;
    in_item_t          cur_reg, cur_next;
    out_item_t         out_reg, out_next;
    logic              out_valid_reg, out_valid_next;
    logic [KEY_W-1:0]  pend_key_reg, pend_key_next;
    logic [CNT_W-1:0]  pend_occ_reg, pend_occ_next;
    logic              pend_valid_reg, pend_valid_next;

    logic [DEPTH-1:0]   hit_vec, lru_vec;
    logic               hit_any, lru_any, free_any;
    logic [IDX_W-1:0]   hit_idx, lru_idx, free_idx, hit_rank;
    logic [CNT_W-1:0]   occ_dec;
    logic [TIME_W-1:0]  age;
    logic [CNT32_W-1:0] icnt_inc;
    logic               run, evict_ok, can_emit;

    assign m_data    = out_reg;
    assign m_valid   = out_valid_reg;
    assign job_ready = (state_reg == ES_IDLE);
    assign can_emit  = !out_valid_reg || m_ready;
    assign occ_dec   = occ_reg - 1'b1;
    assign icnt_inc  = icnt_reg + 1'b1;
    assign run       = (clean_reg != '0) && (icnt_inc >= clean_reg);

    always_comb begin
        hit_idx  = '0;
        lru_idx  = '0;
        free_idx = '0;
        free_any = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            hit_vec[i] = valid_reg[i] && (key_reg[i] == cur_reg.key);
            lru_vec[i] = valid_reg[i] && (rank_reg[i] == occ_dec[IDX_W-1:0]);
            if (hit_vec[i]) hit_idx = IDX_W'(i);
            if (lru_vec[i]) lru_idx = IDX_W'(i);
        end
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_idx = IDX_W'(i);
                free_any = 1'b1;
            end
        end
        hit_any  = |hit_vec;
        lru_any  = |lru_vec;
        hit_rank = rank_reg[hit_idx];
        age      = time_reg - stamp_reg[lru_idx];
        evict_ok = lru_any && (CW'(occ_reg) > CW'(thr_reg)) &&
                   ((age_thr_reg == '0) || (CFG_W'(age) >= age_thr_reg));
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ES_IDLE: begin
                if (job_valid) state_next = ES_EXEC;
            end
            ES_EXEC: begin
                if (can_emit) begin
                    state_next = (cur_reg.op == OP_TICK && run) ? ES_EVICT : ES_IDLE;
                end
            end
            ES_EVICT: begin
                if (can_emit && !evict_ok) state_next = ES_IDLE;
            end
            default: state_next = ES_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        key_next        = key_reg;
        stamp_next      = stamp_reg;
        rank_next       = rank_reg;
        valid_next      = valid_reg;
        occ_next        = occ_reg;
        time_next       = time_reg;
        icnt_next       = icnt_reg;
        thr_next        = thr_reg;
        age_thr_next    = age_thr_reg;
        clean_next      = clean_reg;
        cur_next        = cur_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        pend_key_next   = pend_key_reg;
        pend_occ_next   = pend_occ_reg;
        pend_valid_next = pend_valid_reg;

        if (cfg_wen) begin
            case (cfg_index)
                CFG_SIZE_THR:  thr_next     = cfg_wdata[THR_W-1:0];
                CFG_AGE_THR:   age_thr_next = cfg_wdata;
                CFG_CLEAN_INT: clean_next   = cfg_wdata;
                default: ;
            endcase
        end

        case (state_reg)
            ES_IDLE: begin
                if (job_valid) cur_next = job;
            end
            ES_EXEC: begin
                if (can_emit) begin
                    out_next.evicted_key = cur_reg.key;
                    out_next.last        = 1'b1;
                    out_next.occupancy   = OCC_W'(occ_reg);
                    case (cur_reg.op)
                        OP_ADD: begin
                            out_valid_next = 1'b1;
                            if (hit_any) begin
                                for (int i = 0; i < DEPTH; i++) begin
                                    if (valid_reg[i] && rank_reg[i] < hit_rank)
                                        rank_next[i] = rank_reg[i] + 1'b1;
                                end
                                rank_next[hit_idx]  = '0;
                                stamp_next[hit_idx] = time_reg;
                                out_next.status     = STS_REFRESHED;
                            end else if (!free_any) begin
                                out_next.status = STS_FULL;
                            end else begin
                                for (int i = 0; i < DEPTH; i++) begin
                                    if (valid_reg[i]) rank_next[i] = rank_reg[i] + 1'b1;
                                end
                                valid_next[free_idx] = 1'b1;
                                key_next[free_idx]   = cur_reg.key;
                                stamp_next[free_idx] = time_reg;
                                rank_next[free_idx]  = '0;
                                occ_next             = occ_reg + 1'b1;
                                out_next.status      = STS_ADDED;
                                out_next.occupancy   = OCC_W'(occ_reg + 1'b1);
                            end
                        end
                        OP_REMOVE: begin
                            out_valid_next = 1'b1;
                            if (hit_any) begin
                                valid_next[hit_idx] = 1'b0;
                                for (int i = 0; i < DEPTH; i++) begin
                                    if (valid_reg[i] && rank_reg[i] > hit_rank)
                                        rank_next[i] = rank_reg[i] - 1'b1;
                                end
                                occ_next           = occ_dec;
                                out_next.status    = STS_REMOVED;
                                out_next.occupancy = OCC_W'(occ_dec);
                            end else begin
                                out_next.status = STS_NOT_FOUND;
                            end
                        end
                        OP_CLEAR: begin
                            out_valid_next     = 1'b1;
                            valid_next         = '0;
                            occ_next           = '0;
                            out_next.status    = STS_CLEARED;
                            out_next.occupancy = '0;
                        end
                        OP_TICK: begin
                            time_next = time_reg + 1'b1;
                            if (clean_reg != '0) icnt_next = run ? '0 : icnt_inc;
                            pend_valid_next = 1'b0;
                            if (!run) begin
                                out_valid_next  = 1'b1;
                                out_next.status = STS_TICK_NONE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ES_EVICT: begin
                if (can_emit) begin
                    if (evict_ok) begin
                        valid_next[lru_idx] = 1'b0;
                        occ_next            = occ_dec;
                        if (pend_valid_reg) begin
                            out_valid_next       = 1'b1;
                            out_next.status      = STS_EVICTED;
                            out_next.evicted_key = pend_key_reg;
                            out_next.occupancy   = OCC_W'(pend_occ_reg);
                            out_next.last        = 1'b0;
                        end
                        pend_key_next   = key_reg[lru_idx];
                        pend_occ_next   = occ_dec;
                        pend_valid_next = 1'b1;
                    end else begin
                        out_valid_next  = 1'b1;
                        out_next.last   = 1'b1;
                        pend_valid_next = 1'b0;
                        if (pend_valid_reg) begin
                            out_next.status      = STS_EVICTED;
                            out_next.evicted_key = pend_key_reg;
                            out_next.occupancy   = OCC_W'(pend_occ_reg);
                        end else begin
                            out_next.status      = STS_TICK_NONE;
                            out_next.evicted_key = cur_reg.key;
                            out_next.occupancy   = OCC_W'(occ_reg);
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            occ_reg        <= '0;
            time_reg       <= '0;
            icnt_reg       <= '0;
            thr_reg        <= THR_W'(8);
            age_thr_reg    <= '0;
            clean_reg      <= '0;
            state_reg      <= ES_IDLE;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            valid_reg      <= valid_next;
            occ_reg        <= occ_next;
            time_reg       <= time_next;
            icnt_reg       <= icnt_next;
            thr_reg        <= thr_next;
            age_thr_reg    <= age_thr_next;
            clean_reg      <= clean_next;
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg      <= key_next;
        stamp_reg    <= stamp_next;
        rank_reg     <= rank_next;
        cur_reg      <= cur_next;
        out_reg      <= out_next;
        pend_key_reg <= pend_key_next;
        pend_occ_reg <= pend_occ_next;
    end

`ifndef NO_ASSERTIONS
    a_occ_matches_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg == CNT_W'($countones(valid_reg)))
        else $error("occupancy count out of step with valid bits");

    a_unique_keys: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(hit_vec))
        else $error("key present in more than one entry");

    a_evict_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ES_EVICT && can_emit && evict_ok) |=> !valid_reg[$past(lru_idx)])
        else $error("evicted entry still valid");

    a_take_then_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (job_valid && job_ready) |=> state_reg == ES_EXEC)
        else $error("taken item not executed");
`endif

endmodule

### src/lru_table_age_size_eviction.sv
// Recency-ordered key table with age and size driven eviction: top level.
// Items enter a two-entry queue and are executed one at a time by the table engine.
// Add, remove and clear are taken, then executed against all entries in parallel.
// A tick is handled alike; if a cleaning pass runs, the engine evicts one key per step
// and ends with a final decision. The sequencer is single-issue: no new item is
// taken until the last is through. A result waits in an output
// register while further items queue. No clearing pass is needed after reset.
module lru_table_age_size_eviction #(
    parameter int DEPTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lte_pkg::in_item_t             s_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    output lte_pkg::out_item_t            m_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    input  logic                          cfg_wen,
    input  logic [lte_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lte_pkg::CFG_W-1:0]     cfg_wdata
);
    import lte_pkg::*;

    in_item_t q_item;
    logic     q_valid, q_ready;

    lte_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .q_item  (q_item),
        .q_valid (q_valid),
        .q_ready (q_ready)
    );

    lte_engine #(.DEPTH(DEPTH)) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job       (q_item),
        .job_valid (q_valid),
        .job_ready (q_ready),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready)
    );

endmodule

### sim/lte_checker.sv
// Checker: watches both channels, predicts the table's results and compares them.
module lte_checker
    import lte_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  in_item_t           s_data,
    input  logic               s_valid,
    input  logic               s_ready,
    input  out_item_t          m_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic               cfg_wen,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]   cfg_wdata,
    output int                 fail_count,
    output int                 pending
);
    localparam int N = 16;

    logic [KEY_W-1:0]  tbl_key [N];
    logic [TIME_W-1:0] tbl_stamp [N];
    logic              tbl_valid [N];
    int                tbl_rank [N];
    logic [TIME_W-1:0] now_time;
    logic [31:0]       ival_count;
    logic [THR_W-1:0]  size_thr;
    logic [31:0]       age_thr;
    logic [31:0]       clean_ival;

    out_item_t expected_q[$];

    assign pending = expected_q.size();

    function automatic out_item_t mk(status_t st, logic [KEY_W-1:0] k, int occ, bit lst);
        out_item_t r;
        r.status = st;
        r.evicted_key = k;
        r.occupancy = occ[OCC_W-1:0];
        r.last = lst;
        return r;
    endfunction

    task automatic predict_item(in_item_t it);
        int occ;
        int hit;
        int old;
        int slot;
        int lru;
        int n;
        bit run;
        logic [TIME_W-1:0] age;
        occ = 0;
        hit = -1;
        for (int i = 0; i < N; i++) begin
            if (tbl_valid[i]) begin
                occ++;
                if (tbl_key[i] == it.key) hit = i;
            end
        end
        case (it.op)
            OP_ADD: begin
                if (hit >= 0) begin
                    old = tbl_rank[hit];
                    for (int i = 0; i < N; i++)
                        if (tbl_valid[i] && tbl_rank[i] < old) tbl_rank[i]++;
                    tbl_rank[hit] = 0;
                    tbl_stamp[hit] = now_time;
                    expected_q.push_back(mk(STS_REFRESHED, it.key, occ, 1));
                end else if (occ >= N) begin
                    expected_q.push_back(mk(STS_FULL, it.key, occ, 1));
                end else begin
                    slot = 0;
                    while (tbl_valid[slot]) slot++;
                    for (int i = 0; i < N; i++)
                        if (tbl_valid[i]) tbl_rank[i]++;
                    tbl_valid[slot] = 1;
                    tbl_key[slot] = it.key;
                    tbl_stamp[slot] = now_time;
                    tbl_rank[slot] = 0;
                    expected_q.push_back(mk(STS_ADDED, it.key, occ + 1, 1));
                end
            end
            OP_REMOVE: begin
                if (hit < 0) begin
                    expected_q.push_back(mk(STS_NOT_FOUND, it.key, occ, 1));
                end else begin
                    old = tbl_rank[hit];
                    tbl_valid[hit] = 0;
                    for (int i = 0; i < N; i++)
                        if (tbl_valid[i] && tbl_rank[i] > old) tbl_rank[i]--;
                    expected_q.push_back(mk(STS_REMOVED, it.key, occ - 1, 1));
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < N; i++) tbl_valid[i] = 0;
                expected_q.push_back(mk(STS_CLEARED, it.key, 0, 1));
            end
            default: begin
                now_time = now_time + 1;
                run = 0;
                n = 0;
                if (clean_ival != 0) begin
                    ival_count = ival_count + 1;
                    if (ival_count >= clean_ival) begin
                        ival_count = 0;
                        run = 1;
                    end
                end
                while (run && occ > size_thr && occ > 0) begin
                    lru = -1;
                    for (int i = 0; i < N; i++)
                        if (tbl_valid[i] && tbl_rank[i] == occ - 1) lru = i;
                    if (lru < 0) break;
                    age = now_time - tbl_stamp[lru];
                    if (age_thr != 0 && age < age_thr) break;
                    tbl_valid[lru] = 0;
                    occ--;
                    expected_q.push_back(mk(STS_EVICTED, tbl_key[lru], occ, 0));
                    n++;
                end
                if (n == 0) expected_q.push_back(mk(STS_TICK_NONE, it.key, occ, 1));
                else expected_q[$].last = 1;
            end
        endcase
    endtask

    task automatic compare_result(out_item_t got);
        out_item_t want;
        if (expected_q.size() == 0) begin
            $error("unexpected result item: %p", got);
            fail_count++;
            return;
        end
        want = expected_q.pop_front();
        if (got.status !== want.status) begin
            $error("status: expected %s actual %0d", want.status.name(), got.status);
            fail_count++;
        end
        if (got.evicted_key !== want.evicted_key) begin
            $error("evicted_key: expected %h actual %h", want.evicted_key, got.evicted_key);
            fail_count++;
        end
        if (got.occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d actual %0d", want.occupancy, got.occupancy);
            fail_count++;
        end
        if (got.last !== want.last) begin
            $error("last: expected %0d actual %0d", want.last, got.last);
            fail_count++;
        end
    endtask

    initial fail_count = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < N; i++) tbl_valid[i] = 0;
            now_time = '0;
            ival_count = '0;
            size_thr = 5'd8;
            age_thr = '0;
            clean_ival = '0;
            expected_q.delete();
        end else begin
            if (cfg_wen) begin
                case (cfg_index)
                    CFG_SIZE_THR:  size_thr = cfg_wdata[THR_W-1:0];
                    CFG_AGE_THR:   age_thr = cfg_wdata;
                    CFG_CLEAN_INT: clean_ival = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) predict_item(s_data);
            if (m_valid && m_ready) compare_result(m_data);
        end
    end
endmodule

### sim/tb_lru_table_age_size_eviction.sv
// Testbench top: drives table operations and configuration, reports the verdict.
module tb_lru_table_age_size_eviction;
    import lte_pkg::*;

    logic aclk = 0;
    logic aresetn = 0;
    in_item_t s_data = '0;
    logic s_valid = 0;
    logic s_ready;
    out_item_t m_data;
    logic m_valid;
    logic m_ready = 0;
    logic cfg_wen = 0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    int fail_count;
    int pending;
    int cycle_count = 0;
    bit calm = 0;
    logic [KEY_W-1:0] key_pool[24];

    always #6 aclk = ~aclk;

    lru_table_age_size_eviction dut (.*);

    lte_checker u_checker (.*);

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > 400000) begin
            $display("lru_table_age_size_eviction regression: fail");
            $finish;
        end
    end

    // result side stalls in bursts
    initial begin
        int gap;
        forever begin
            @(negedge aclk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                m_ready <= 0;
                gap = $urandom_range(1, 7);
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1;
        end
    end

    // s_ready only moves at the rising edge, so its value at the falling edge
    // tells whether the coming edge takes the item
    task automatic send(op_t op, logic [KEY_W-1:0] k);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 0;
            gap = $urandom_range(1, 7);
            repeat (gap) @(negedge aclk);
        end
        s_data <= '{op: op, key: k};
        s_valid <= 1;
        while (!s_ready) @(negedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] v);
        s_valid <= 0;
        while (pending != 0) @(negedge aclk);
        repeat (24) @(negedge aclk);
        cfg_index <= idx;
        cfg_wdata <= v;
        cfg_wen <= 1;
        @(negedge aclk);
        cfg_wen <= 0;
    endtask

    task automatic random_phase(int count);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 50)
                send(OP_ADD, key_pool[$urandom_range(0, 23)]);
            else if (r < 65)
                send(OP_REMOVE, $urandom_range(0, 9) == 0 ? {$urandom, $urandom}
                                                          : key_pool[$urandom_range(0, 23)]);
            else if (r < 97)
                send(OP_TICK, {$urandom, $urandom});
            else
                send(OP_CLEAR, {$urandom, $urandom});
        end
    endtask

    initial begin
        for (int i = 0; i < 24; i++) key_pool[i] = {$urandom, $urandom};
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (9) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // directed: fill past capacity, refresh, remove, ticks, clear
        for (int i = 0; i < 17; i++) send(OP_ADD, key_pool[i]);
        send(OP_ADD, key_pool[3]);
        send(OP_REMOVE, key_pool[1]);
        send(OP_REMOVE, key_pool[1]);
        send(OP_TICK, '1);
        write_reg(CFG_CLEAN_INT, 32'd1);
        send(OP_TICK, '0);
        send(OP_CLEAR, 64'h5a5a_a5a5_0f0f_f0f0);
        send(OP_TICK, '0);

        write_reg(CFG_SIZE_THR, 5'd2);
        write_reg(CFG_AGE_THR, 32'd3);
        write_reg(CFG_CLEAN_INT, 32'd2);
        random_phase(90);
        write_reg(CFG_SIZE_THR, 5'd0);
        write_reg(CFG_AGE_THR, 32'd0);
        write_reg(CFG_CLEAN_INT, 32'd5);
        random_phase(80);
        write_reg(CFG_SIZE_THR, 5'd16);
        write_reg(CFG_AGE_THR, 32'hFFFF_FFFF);
        write_reg(CFG_CLEAN_INT, 32'hFFFF_FFFF);
        random_phase(40);
        write_reg(CFG_SIZE_THR, 5'd31);
        write_reg(CFG_CLEAN_INT, 32'd1);
        random_phase(30);
        write_reg(CFG_SIZE_THR, 5'd4);
        write_reg(CFG_AGE_THR, 32'd1);
        write_reg(CFG_CLEAN_INT, 32'd3);
        random_phase(70);
        calm = 1;
        random_phase(40);
        s_valid <= 0;

        while (pending != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
        if (fail_count == 0)
            $display("lru_table_age_size_eviction regression: pass");
        else
            $display("lru_table_age_size_eviction regression: fail");
        $finish;
    end
endmodule
